FILE: rtl/satf_pkg.sv
// ----------------------------------------------------------------------------
// satf_pkg: shared types and constants of the set-associative tag store
// Sizes of the address, tag and set memories, the configuration register
// indexes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package satf_pkg;

    // Geometry
    localparam int ADDR_BITS = 26;
    localparam int MAX_SETS  = 1024;
    localparam int MAX_WAYS  = 16;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int WCNT_W    = WAY_W + 1;
    localparam int OFF_MIN   = 4;
    localparam int IDX_MAX   = 10;
    localparam int TAG_W     = ADDR_BITS - OFF_MIN;
    localparam int SHIFT_W   = 5;

    // Stream words, padded to whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // Configuration registers
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int IDX_BITS_W   = 4;
    localparam int OFF_BITS_W   = 3;

    localparam logic [IDX_BITS_W-1:0] IDX_BITS_RST = 4'd7;
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 3'd5;
    localparam logic [WCNT_W-1:0]     WAY_CNT_RST  = 5'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INDEX_BITS  = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAY_COUNT   = 2'd2
    } cfg_reg_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Per-set metadata row: valid bit per way and FIFO pointer
    typedef struct packed {
        logic [MAX_WAYS-1:0] valid;
        logic [WAY_W-1:0]    ptr;
    } meta_t;

    // Controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic load;
        logic commit;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: rtl/set_assoc_cache_tag_fifo.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_fifo: N-way set-associative tag store, FIFO replacement
//
// Input stream s_axis carries one byte address per word. The block splits it
// into line offset, set index and tag from the configured bit counts, looks up
// the set and returns one word on m_axis: hit = 1, or 0 for a miss. A miss
// fills the lowest invalid way in use, or, with all ways valid, the way named
// by the set's FIFO pointer; each fill advances that pointer modulo way_count.
//
// Sequence: the accept cycle reads the set's tag row and metadata row (one
// memory port each); the LOOKUP state then compares all ways, writes the fill
// back and loads the output register. s_axis_tready rises again once the
// controller is back in IDLE, so each address is committed before the next.
// The output register lets the next address be accepted while a result waits;
// if m_axis stays stalled, the lookup holds until the output register frees.
//
// Reset: configuration returns to index_bits 7, offset_bits 5, way_count 4, and a
// sweep of all 1024 sets clears valid bits and pointers; s_axis_tready stays low
// for its length. Config writes (cfg_we/cfg_addr/cfg_wdata) apply from the next
// address; the user must make them only while idle; the block does not check.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [satf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [25:0] address
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [satf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [0] hit
    input  logic                                cfg_we,
    input  logic [satf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [satf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    satf_pkg::ctrl_cmd_t cmd;
    satf_pkg::dp_sts_t   sts;
    logic                hit;

    satf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    satf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .address   (s_axis_tdata[satf_pkg::ADDR_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .hit       (hit)
    );

    // Result word, hit in bit 0
    assign m_axis_tdata = {{(satf_pkg::OUT_TDATA_W-1){1'b0}}, hit};

endmodule

FILE: rtl/satf_ctrl.sv
// ----------------------------------------------------------------------------
// satf_ctrl: sequencer of the tag store
// Runs the metadata clearing sweep after reset, then steps each word through
// a read step and a compare/write-back step that waits for the output register.
// ----------------------------------------------------------------------------
module satf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  satf_pkg::dp_sts_t     sts,
    output satf_pkg::ctrl_cmd_t   cmd
);

    satf_pkg::state_t state_reg;
    satf_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= satf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            satf_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = satf_pkg::ST_IDLE;
                end
            end
            satf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = satf_pkg::ST_LOOKUP;
                end
            end
            satf_pkg::ST_LOOKUP:
            begin
                // finish only when the output register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = satf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = satf_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/satf_dp.sv
// ----------------------------------------------------------------------------
// satf_dp: datapath of the tag store
// Configuration registers, address split, tag and metadata memories, way
// compare with victim selection, and the output register.
// ----------------------------------------------------------------------------
module satf_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  satf_pkg::ctrl_cmd_t                     cmd,
    output satf_pkg::dp_sts_t                       sts,
    input  logic [satf_pkg::ADDR_BITS-1:0]          address,
    input  logic                                    cfg_we,
    input  logic [satf_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [satf_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    hit
);

    // Configuration
    logic [satf_pkg::IDX_BITS_W-1:0] idx_bits_reg;
    logic [satf_pkg::OFF_BITS_W-1:0] off_bits_reg;
    logic [satf_pkg::WCNT_W-1:0]     way_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_bits_reg <= satf_pkg::IDX_BITS_RST;
            off_bits_reg <= satf_pkg::OFF_BITS_RST;
            way_cnt_reg  <= satf_pkg::WAY_CNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                satf_pkg::CFG_INDEX_BITS:  idx_bits_reg <= cfg_wdata[satf_pkg::IDX_BITS_W-1:0];
                satf_pkg::CFG_OFFSET_BITS: off_bits_reg <= cfg_wdata[satf_pkg::OFF_BITS_W-1:0];
                satf_pkg::CFG_WAY_COUNT:   way_cnt_reg  <= cfg_wdata[satf_pkg::WCNT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Address split: offset clamped to at least 4, index to at most 10
    logic [satf_pkg::SHIFT_W-1:0]   ob;
    logic [satf_pkg::SHIFT_W-1:0]   ib;
    logic [satf_pkg::ADDR_BITS-1:0] addr_sh;
    logic [satf_pkg::SET_W:0]       set_mask;
    logic [satf_pkg::SET_W-1:0]     set_comb;
    logic [satf_pkg::ADDR_BITS-1:0] tag_sh;
    logic [satf_pkg::TAG_W-1:0]     tag_comb;

    always_comb
    begin
        ob = (off_bits_reg < satf_pkg::OFF_BITS_W'(satf_pkg::OFF_MIN))
            ? satf_pkg::SHIFT_W'(satf_pkg::OFF_MIN)
            : satf_pkg::SHIFT_W'(off_bits_reg);
        ib = (idx_bits_reg > satf_pkg::IDX_BITS_W'(satf_pkg::IDX_MAX))
            ? satf_pkg::SHIFT_W'(satf_pkg::IDX_MAX)
            : satf_pkg::SHIFT_W'(idx_bits_reg);
        addr_sh  = address >> ob;
        set_mask = ((satf_pkg::SET_W+1)'(1) << ib) - (satf_pkg::SET_W+1)'(1);
        set_comb = addr_sh[satf_pkg::SET_W-1:0] & set_mask[satf_pkg::SET_W-1:0];
        tag_sh   = address >> (ob + ib);
        tag_comb = tag_sh[satf_pkg::TAG_W-1:0];
    end

    // Memories and clearing counter
    logic [satf_pkg::MAX_WAYS-1:0][satf_pkg::TAG_W-1:0] tag_mem [satf_pkg::MAX_SETS];
    satf_pkg::meta_t                                    meta_mem [satf_pkg::MAX_SETS];

    logic [satf_pkg::MAX_WAYS-1:0][satf_pkg::TAG_W-1:0] tag_rd_reg;
    satf_pkg::meta_t                                    meta_rd_reg;
    logic [satf_pkg::SET_W-1:0]                         set_reg;
    logic [satf_pkg::TAG_W-1:0]                         tag_reg;
    logic [satf_pkg::SET_W-1:0]                         clr_cnt_reg;

    logic                      miss;
    logic [satf_pkg::WAY_W-1:0] victim;
    satf_pkg::meta_t           meta_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + satf_pkg::SET_W'(1);
        end
    end

    assign sts.clr_done = (clr_cnt_reg == satf_pkg::SET_W'(satf_pkg::MAX_SETS - 1));

    // Metadata memory: sweep write, fill write, registered row read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
        begin
            meta_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.commit && miss)
        begin
            meta_mem[set_reg] <= meta_new;
        end
        if (cmd.load)
        begin
            meta_rd_reg <= meta_mem[set_comb];
        end
    end

    // Tag memory: one way written per fill, whole set read
    always_ff @(posedge clk)
    begin
        if (cmd.commit && miss)
        begin
            tag_mem[set_reg][victim] <= tag_reg;
        end
        if (cmd.load)
        begin
            tag_rd_reg <= tag_mem[set_comb];
            set_reg    <= set_comb;
            tag_reg    <= tag_comb;
        end
    end

    // Way compare and victim choice
    logic [satf_pkg::WCNT_W-1:0]   ways;
    logic [satf_pkg::MAX_WAYS-1:0] in_use;
    logic [satf_pkg::MAX_WAYS-1:0] match;
    logic [satf_pkg::MAX_WAYS-1:0] free;
    logic [satf_pkg::WAY_W-1:0]    first_free;
    logic [satf_pkg::WCNT_W-1:0]   ptr;
    logic [satf_pkg::WCNT_W-1:0]   ptr_inc;
    logic [satf_pkg::WCNT_W-1:0]   ptr_adv;

    always_comb
    begin
        ways = way_cnt_reg;
        if (ways == '0)
        begin
            ways = satf_pkg::WCNT_W'(1);
        end
        if (ways > satf_pkg::WCNT_W'(satf_pkg::MAX_WAYS))
        begin
            ways = satf_pkg::WCNT_W'(satf_pkg::MAX_WAYS);
        end

        first_free = '0;
        for (int w = satf_pkg::MAX_WAYS - 1; w >= 0; w--)
        begin
            in_use[w] = (satf_pkg::WCNT_W'(w) < ways);
            match[w]  = in_use[w] && meta_rd_reg.valid[w] && (tag_rd_reg[w] == tag_reg);
            free[w]   = in_use[w] && !meta_rd_reg.valid[w];
            if (free[w])
            begin
                first_free = satf_pkg::WAY_W'(w);
            end
        end

        miss = ~|match;

        // stale pointer beyond the ways in use counts as zero
        ptr = satf_pkg::WCNT_W'(meta_rd_reg.ptr);
        if (ptr >= ways)
        begin
            ptr = '0;
        end
        ptr_inc = ptr + satf_pkg::WCNT_W'(1);
        ptr_adv = (ptr_inc >= ways) ? '0 : ptr_inc;

        victim = (|free) ? first_free : ptr[satf_pkg::WAY_W-1:0];

        meta_new                = meta_rd_reg;
        meta_new.valid[victim]  = 1'b1;
        meta_new.ptr            = ptr_adv[satf_pkg::WAY_W-1:0];
    end

    // Output register
    logic out_valid_reg;
    logic hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg <= !miss;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;

endmodule
